### rtl/core/dmxd_pkg.sv
package dmxd_pkg;

  // Run modes as seen on the run_mode output
  typedef enum logic [1:0] {
    MODE_DIMMER = 2'd0,
    MODE_SKIP   = 2'd1,
    MODE_GRAD   = 2'd2,
    MODE_STROBE = 2'd3
  } mode_t;

  // What the back end has to do with one queued item
  typedef enum logic [1:0] {
    CMD_NOP    = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_EFFECT = 2'd2,
    CMD_DIMMER = 2'd3
  } cmd_kind_t;

  localparam int MAX_CHANNELS = 6;
  localparam int QUEUE_DEPTH  = 2;
  localparam int TIMER_W      = 11;
  localparam int SPEED_W      = 4;

  localparam logic [7:0] START_CODE_DIMMER = 8'h00;
  localparam logic [7:0] GRAD_THRESHOLD    = 8'd127;
  localparam logic [11:0] STROBE_BASE      = 12'd2000;
  localparam logic [11:0] STROBE_STEP      = 12'd200;
  localparam logic [TIMER_W-1:0] EFFECT_BASE = 11'd10;

  localparam int NUM_THRESH = 9;
  localparam logic [NUM_THRESH-1:0][7:0] SPEED_THRESH = {
    8'd230, 8'd205, 8'd180, 8'd155, 8'd130, 8'd105, 8'd80, 8'd55, 8'd20
  };

  typedef logic [MAX_CHANNELS-1:0][7:0] chan_vec_t;

  // One classified item in the queue
  typedef struct packed {
    cmd_kind_t           kind;
    mode_t               mode;
    logic [SPEED_W-1:0]  speed;
    chan_vec_t           chan;
  } cmd_t;

  // Raw speed byte to level 0..9: highest threshold exceeded
  function automatic logic [SPEED_W-1:0] map_speed(input logic [7:0] raw);
    logic [SPEED_W-1:0] level;
    level = '0;
    for (int k = 0; k < NUM_THRESH; k++) begin
      if (raw > SPEED_THRESH[k]) begin
        level = SPEED_W'(k + 1);
      end
    end
    return level;
  endfunction

  // Timer reload for the active effect mode
  function automatic logic [TIMER_W-1:0] reload_value(input mode_t mode,
                                                      input logic [SPEED_W-1:0] spd);
    logic [11:0] strobe;
    strobe = STROBE_BASE - 12'(spd) * STROBE_STEP;
    if (mode == MODE_STROBE) begin
      return strobe[TIMER_W-1:0];
    end
    return EFFECT_BASE - TIMER_W'(spd);
  endfunction

endpackage

### rtl/core/dmxd_front.sv
module dmxd_front #(
  parameter int NUM_CHANNELS = 6
) (
  input  logic              req_type,
  input  logic [7:0]        start_code,
  input  logic [7:0]        dimmer_level,
  input  logic [7:0]        strobe_level,
  input  logic [7:0]        speed_level,
  input  logic [7:0]        effect_level,
  input  dmxd_pkg::chan_vec_t color,
  output dmxd_pkg::cmd_t    cmd
);
  import dmxd_pkg::*;

  logic [15:0] prod [MAX_CHANNELS];

  // Dimmer scaling, one 8x8 product per channel; unused channels read zero
  always_comb begin
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      prod[i] = 16'(dimmer_level) * 16'(color[i]);
    end
  end

  // Classify the item
  always_comb begin
    cmd.kind  = CMD_NOP;
    cmd.mode  = MODE_DIMMER;
    cmd.speed = map_speed(speed_level);
    cmd.chan  = '0;
    if (req_type) begin
      cmd.kind = CMD_TICK;
    end else if (start_code == START_CODE_DIMMER) begin
      if (effect_level != 8'd0) begin
        cmd.kind = CMD_EFFECT;
        cmd.mode = (effect_level >= GRAD_THRESHOLD) ? MODE_GRAD : MODE_SKIP;
      end else if (strobe_level != 8'd0) begin
        cmd.kind = CMD_EFFECT;
        cmd.mode = MODE_STROBE;
      end else begin
        cmd.kind = CMD_DIMMER;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
          if (i < NUM_CHANNELS) begin
            cmd.chan[i] = prod[i][15:8];
          end
        end
      end
    end
  end

endmodule

### rtl/core/dmxd_queue.sv
module dmxd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dmxd_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output dmxd_pkg::cmd_t pop_data
);
  import dmxd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/dmxd_back.sv
module dmxd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  dmxd_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                res_valid,
  input  logic                res_ready,
  output dmxd_pkg::mode_t     run_mode,
  output logic [3:0]          speed_step,
  output logic                channels_valid,
  output logic                effect_step,
  output dmxd_pkg::chan_vec_t chan_out
);
  import dmxd_pkg::*;

  mode_t              mode;
  mode_t              mode_next;
  logic [SPEED_W-1:0] speed;
  logic [SPEED_W-1:0] speed_next;
  logic [TIMER_W-1:0] timer;
  logic [TIMER_W-1:0] timer_next;
  logic               valid_next;
  logic               step_next;
  chan_vec_t          chan_next;

  assign cmd_pop = cmd_valid && (!res_valid || res_ready);

  // Apply one item to the mode, speed and timer state
  always_comb begin
    mode_next  = mode;
    speed_next = speed;
    timer_next = timer;
    valid_next = 1'b0;
    chan_next  = '0;
    case (cmd.kind)
      CMD_TICK: begin
        if (timer != '0) begin
          timer_next = timer - 1'b1;
        end
      end
      CMD_EFFECT: begin
        mode_next  = cmd.mode;
        speed_next = cmd.speed;
      end
      CMD_DIMMER: begin
        mode_next  = MODE_DIMMER;
        valid_next = 1'b1;
        chan_next  = cmd.chan;
      end
      default: begin
      end
    endcase
    step_next = (mode_next != MODE_DIMMER) && (timer_next == '0);
    if (step_next) begin
      timer_next = reload_value(mode_next, speed_next);
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_DIMMER;
      speed     <= '0;
      timer     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd_pop) begin
        mode      <= mode_next;
        speed     <= speed_next;
        timer     <= timer_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      run_mode       <= mode_next;
      speed_step     <= speed_next;
      channels_valid <= valid_next;
      effect_step    <= step_next;
      chan_out       <= chan_next;
    end
  end

  // Checks
  a_pop_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> res_valid)
    else $error("popped item produced no result");

  a_step_not_dimmer: assert property (@(posedge clk) disable iff (rst)
    res_valid && effect_step |-> run_mode != MODE_DIMMER)
    else $error("effect step in dimmer mode");

  a_chan_dimmer: assert property (@(posedge clk) disable iff (rst)
    res_valid && channels_valid |-> run_mode == MODE_DIMMER && !effect_step)
    else $error("channel update outside dimmer mode");

  a_timer_range: assert property (@(posedge clk) disable iff (rst)
    timer <= TIMER_W'(STROBE_BASE))
    else $error("effect timer out of range");

endmodule

### rtl/core/dmx_frame_mode_decoder.sv
// DMX frame mode decoder. Each item is a received DMX frame (req_type 0) or a
// millisecond tick (req_type 1); every accepted item yields exactly one result.
// A front stage classifies the item and scales the colours, a two-entry queue
// holds classified items, and a back stage updates mode, speed and the effect
// timer and registers the result. One item is accepted per clock while results
// are taken. An accepted item is written into the queue, and the back stage pops
// it and registers its result when no earlier result is waiting or that result
// is being taken. While a result waits, the queue fills both of its entries;
// after that req_ready drops until the result is taken.
module dmx_frame_mode_decoder #(
  parameter int NUM_CHANNELS = 6
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  logic       req_type,
  input  logic [7:0] start_code,
  input  logic [7:0] dimmer_level,
  input  logic [7:0] strobe_level,
  input  logic [7:0] speed_level,
  input  logic [7:0] effect_level,
  input  logic [7:0] color_1,
  input  logic [7:0] color_2,
  input  logic [7:0] color_3,
  input  logic [7:0] color_4,
  input  logic [7:0] color_5,
  input  logic [7:0] color_6,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [1:0] run_mode,
  output logic [3:0] speed_step,
  output logic       channels_valid,
  output logic       effect_step,
  output logic [7:0] out_1,
  output logic [7:0] out_2,
  output logic [7:0] out_3,
  output logic [7:0] out_4,
  output logic [7:0] out_5,
  output logic [7:0] out_6
);
  import dmxd_pkg::*;

  chan_vec_t color;
  chan_vec_t chan_out;
  cmd_t      front_cmd;
  cmd_t      queue_cmd;
  logic      queue_full;
  logic      queue_valid;
  logic      queue_pop;
  mode_t     mode_out;

  assign color = {color_6, color_5, color_4, color_3, color_2, color_1};
  assign req_ready = !queue_full;

  dmxd_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .req_type    (req_type),
    .start_code  (start_code),
    .dimmer_level(dimmer_level),
    .strobe_level(strobe_level),
    .speed_level (speed_level),
    .effect_level(effect_level),
    .color       (color),
    .cmd         (front_cmd)
  );

  dmxd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (req_valid),
    .push_data(front_cmd),
    .full     (queue_full),
    .pop      (queue_pop),
    .not_empty(queue_valid),
    .pop_data (queue_cmd)
  );

  dmxd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (queue_valid),
    .cmd           (queue_cmd),
    .cmd_pop       (queue_pop),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .run_mode      (mode_out),
    .speed_step    (speed_step),
    .channels_valid(channels_valid),
    .effect_step   (effect_step),
    .chan_out      (chan_out)
  );

  assign run_mode = mode_out;
  assign out_1 = chan_out[0];
  assign out_2 = chan_out[1];
  assign out_3 = chan_out[2];
  assign out_4 = chan_out[3];
  assign out_5 = chan_out[4];
  assign out_6 = chan_out[5];

endmodule
